// ===== hw/rtl/bsc_pkg.sv =====
// package: sizes, operation codes and shared types for the bitmap block
`default_nettype none
package bsc_pkg;
  localparam int BITMAP_BITS_DEF = 4096;
  localparam int WORD_W          = 64;
  localparam int OP_W            = 3;
  localparam int IDX_W           = 12;
  localparam int CNT_W           = 13;
  localparam int RUN_W           = 13;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_TEST  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLR   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLRA  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd5;

  localparam logic [RUN_W-1:0] RUN_NONE = '1;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] bit_index;
    logic [IDX_W-1:0] range_end;
  } req_t;

  typedef struct packed {
    logic             result_flag;
    logic [RUN_W-1:0] run_first;
    logic [RUN_W-1:0] run_last;
    logic [CNT_W-1:0] set_count;
    logic [IDX_W-1:0] highest_seen;
    logic             out_of_range;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, issue read of first word
    logic step;      // consume read word, issue next read
    logic finish;    // form result
    logic wipe;      // clear-all sweep write
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic single;    // request finishes after one word
    logic scan_done; // range scan has no more words
    logic wipe_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bsc_if.sv =====
// interface: valid/ready channel carrying one payload struct
`default_nettype none
interface bsc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bitmap_set_clear_range_scan.sv =====
// words of the store visited per item: 1 for single-bit ops, 1 to 64 for range ops
// (one 64-bit word per cycle from the store's read port), 64 for clear all
// one item in flight at a time; next transfer in the cycle after result out
// reset clears state machine, population and highest index, then a clearing
// pass zeroes the bit store with input ready held low
`default_nettype none
module bitmap_set_clear_range_scan #(
  parameter int BITMAP_BITS = bsc_pkg::BITMAP_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  bsc_if.sink      in_ch,
  bsc_if.source    out_ch
);
  import bsc_pkg::*;
  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;

  assign req         = in_ch.data;
  assign out_ch.data = rsp;

  // control sequencer
  bsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .clra(req.operation == OP_CLRA),
    .cmd(cmd), .sts(sts)
  );

  // bit store and scan datapath
  bsc_dp #(.BITMAP_BITS(BITMAP_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/bsc_ctrl.sv =====
// controller: sequences request capture, word scan, clear sweep and result
`default_nettype none
module bsc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic        clra,
  output bsc_pkg::cmd_t    cmd,
  input  wire bsc_pkg::sts_t sts
);
  import bsc_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_FIN = 3'd2,
                         S_OUT = 3'd3, S_WIPE = 3'd4, S_INIT = 3'd5;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      // clearing pass over the store after reset
      S_INIT: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = clra ? S_WIPE : S_RUN;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.single || sts.scan_done) state_nxt = S_FIN;
      end
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bsc_dp.sv =====
// datapath: word memory, population, highest index and range scan
`default_nettype none
module bsc_dp #(
  parameter int BITMAP_BITS = bsc_pkg::BITMAP_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bsc_pkg::req_t req,
  input  wire bsc_pkg::cmd_t cmd,
  output bsc_pkg::sts_t      sts,
  output bsc_pkg::rsp_t      rsp
);
  import bsc_pkg::*;
  localparam int WORDS  = (BITMAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_W);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_q;
  logic [WA_W-1:0]   ra, wa;
  logic              we;
  logic [WORD_W-1:0] wd;

  req_t             q_r;
  logic             oor_r, first_r;
  logic [CNT_W-1:0] pop_r, pop_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] end_r;          // effective scan end
  logic [IDX_W:0]   pos_r;          // index of bit 0 of word in rd_q
  logic             flag_r, found_r, stop_r;
  logic [RUN_W-1:0] rf_r, rl_r;
  logic [WA_W-1:0]  cur_r;          // word address in flight
  logic [WA_W:0]    wipe_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // request decode
  wire [OP_W-1:0] op_in  = req.operation;
  wire            rng_in = (op_in == OP_CHECK) || (op_in == OP_FIND);
  wire            oor_in = (op_in <= OP_FIND) && (op_in != OP_CLRA) &&
                           ((32'(req.bit_index) >= BITMAP_BITS) ||
                            (rng_in && 32'(req.range_end) >= BITMAP_BITS));
  wire [IDX_W-1:0] a_in  = req.bit_index;

  logic last_word, single_op;
  always_comb begin
    single_op     = oor_r || !((q_r.operation == OP_CHECK) ||
                               (q_r.operation == OP_FIND)) || stop_r;
    last_word     = ({1'b0, end_r} < pos_r + (IDX_W+1)'(WORD_W));
    sts.single    = single_op;
    sts.scan_done = last_word;
    sts.wipe_done = (wipe_r == (WA_W+1)'(WORDS - 1));
  end

  // scan one word: bits in [lo,hi] of current word
  logic [WORD_W-1:0] inr, ones;
  logic              w_allset, w_stop, w_found;
  logic [RUN_W-1:0]  w_first, w_last;
  always_comb begin
    inr = '0;
    for (int k = 0; k < WORD_W; k++) begin
      inr[k] = (pos_r + (IDX_W+1)'(k) >= {1'b0, q_r.bit_index}) &&
               (pos_r + (IDX_W+1)'(k) <= {1'b0, end_r});
    end
    ones     = rd_q & inr;
    w_allset = ((rd_q | ~inr) == '1);
    w_found  = found_r;
    w_stop   = 1'b0;
    w_first  = rf_r;
    w_last   = rl_r;
    for (int k = 0; k < WORD_W; k++) begin
      if (inr[k] && !w_stop) begin
        if (!w_found) begin
          if (ones[k]) begin
            w_found = 1'b1;
            w_first = RUN_W'(pos_r) + RUN_W'(k);
            w_last  = w_first;
          end
        end else if (ones[k]) w_last = RUN_W'(pos_r) + RUN_W'(k);
        else w_stop = 1'b1;
      end
    end
  end

  wire [WA_W-1:0] a_word = WA_W'(a_in >> BIT_W);
  wire [BIT_W-1:0] q_bit = q_r.bit_index[BIT_W-1:0];
  wire rbit = rd_q[q_bit];

  always_comb begin
    ra = cur_r; we = 1'b0; wa = cur_r; wd = rd_q;
    pop_nxt = pop_r; hi_nxt = hi_r;
    if (cmd.load) ra = a_word;
    if (cmd.step) ra = cur_r + WA_W'(1);
    if (cmd.wipe) begin
      we = 1'b1; wa = WA_W'(wipe_r); wd = '0;
    end
    if (cmd.step && first_r && !oor_r) begin
      case (q_r.operation)
        OP_SET: begin
          if (q_r.bit_index > hi_r) hi_nxt = q_r.bit_index;
          if (!rbit) begin
            we = 1'b1; wd = rd_q | (WORD_W'(1) << q_bit);
            pop_nxt = pop_r + CNT_W'(1);
          end
        end
        OP_CLR: if (q_r.bit_index <= hi_r && rbit) begin
          we = 1'b1; wd = rd_q & ~(WORD_W'(1) << q_bit);
          pop_nxt = pop_r - CNT_W'(1);
        end
        default: ;
      endcase
    end
    if (cmd.wipe) pop_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= '0; hi_r <= '0; wipe_r <= '0;
    end else begin
      pop_r <= pop_nxt; hi_r <= hi_nxt;
      if (cmd.load)      wipe_r <= '0;
      else if (cmd.wipe) wipe_r <= wipe_r + (WA_W+1)'(1);
    end
  end

  // clear-all sweep is the only writer after reset other than set/clear,
  // so memory must start cleared: a reset sweep is folded into wipe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r     <= req;
      oor_r   <= oor_in;
      first_r <= 1'b1;
      cur_r   <= a_word;
      pos_r   <= {1'b0, a_in[IDX_W-1:BIT_W], {BIT_W{1'b0}}};
      end_r   <= (op_in == OP_FIND && req.range_end > hi_r) ? hi_r : req.range_end;
      found_r <= 1'b0; stop_r <= 1'b0;
      rf_r    <= RUN_NONE; rl_r <= RUN_NONE;
      // empty check is all set; find above highest or empty finds nothing
      flag_r  <= (op_in == OP_CHECK);
      if (op_in == OP_CHECK && req.range_end > hi_r && req.bit_index <= req.range_end)
        flag_r <= 1'b0;
      if (rng_in && (a_in > ((op_in == OP_FIND && req.range_end > hi_r) ?
                              hi_r : req.range_end)))
        stop_r <= 1'b1;
      if (op_in == OP_FIND && a_in > hi_r) stop_r <= 1'b1;
    end else if (cmd.step) begin
      first_r <= 1'b0;
      cur_r   <= cur_r + WA_W'(1);
      pos_r   <= pos_r + (IDX_W+1)'(WORD_W);
      if (!stop_r && !oor_r) begin
        case (q_r.operation)
          OP_SET:  flag_r <= first_r ? 1'b1 : flag_r;
          OP_TEST: flag_r <= (q_r.bit_index <= hi_r) && rbit;
          OP_CLR:  flag_r <= (q_r.bit_index <= hi_r);
          OP_CHECK: if (!w_allset) flag_r <= 1'b0;
          OP_FIND: begin
            found_r <= w_found; rf_r <= w_first; rl_r <= w_last;
            if (w_stop) stop_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end else if (cmd.wipe) begin
      flag_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.result_flag  <= oor_r ? 1'b0 :
                          (q_r.operation == OP_FIND) ? found_r :
                          (q_r.operation > OP_FIND) ? 1'b0 : flag_r;
      rsp.run_first    <= (oor_r || q_r.operation != OP_FIND) ? RUN_NONE : rf_r;
      rsp.run_last     <= (oor_r || q_r.operation != OP_FIND) ? RUN_NONE : rl_r;
      rsp.set_count    <= pop_r;
      rsp.highest_seen <= hi_r;
      rsp.out_of_range <= oor_r;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bsc_chk.sv =====
// checker: port-level properties of the bitmap block, bound to the top
`default_nettype none
module bsc_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire bsc_pkg::rsp_t rsp
);
  import bsc_pkg::*;
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rsp))
    else $error("result changed under stall");
  a_norun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rsp.out_of_range |-> !rsp.result_flag && rsp.run_first == RUN_NONE)
    else $error("ignored op reported data");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item accepted");
endmodule
bind bitmap_set_clear_range_scan bsc_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .rsp(rsp)
);
`default_nettype wire

// ===== test/bsc_scoreboard.sv =====
// checker: watches both channels, predicts each result and compares it field by field
`default_nettype none
module bsc_scoreboard
  import bsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire req_t in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire rsp_t out_data,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = BITMAP_BITS_DEF;

  logic [NBITS-1:0] bits_model;
  logic [CNT_W-1:0] pop_model;
  logic [IDX_W-1:0] high_model;
  rsp_t             expected_rsp_q[$];

  // predicted view of a bit: anything above the highest index reads 0
  function automatic logic visible_bit(int idx);
    if (idx > int'(high_model)) return 1'b0;
    return bits_model[idx];
  endfunction

  function automatic rsp_t apply_bitmap_op(req_t req);
    rsp_t r;
    int   a, b, stop;
    logic found;
    a = int'(req.bit_index);
    b = int'(req.range_end);
    r.result_flag  = 1'b0;
    r.run_first    = RUN_NONE;
    r.run_last     = RUN_NONE;
    r.out_of_range = 1'b0;
    if (req.operation <= OP_FIND && req.operation != OP_CLRA &&
        (a >= NBITS || ((req.operation == OP_CHECK || req.operation == OP_FIND)
                        && b >= NBITS))) begin
      r.out_of_range = 1'b1;
    end else begin
      case (req.operation)
        OP_SET: begin
          if (a > int'(high_model)) high_model = req.bit_index;
          if (!bits_model[a]) begin
            bits_model[a] = 1'b1;
            pop_model     = pop_model + CNT_W'(1);
          end
          r.result_flag = 1'b1;
        end
        OP_TEST: r.result_flag = visible_bit(a);
        OP_CLR: begin
          if (a <= int'(high_model)) begin
            if (bits_model[a]) begin
              bits_model[a] = 1'b0;
              pop_model     = pop_model - CNT_W'(1);
            end
            r.result_flag = 1'b1;
          end
        end
        OP_CLRA: begin
          bits_model    = '0;
          pop_model     = '0;
          r.result_flag = 1'b1;
        end
        OP_CHECK: begin
          r.result_flag = 1'b1;
          for (int i = a; i <= b; i++) begin
            if (!visible_bit(i)) begin
              r.result_flag = 1'b0;
              break;
            end
          end
        end
        OP_FIND: begin
          if (a <= int'(high_model)) begin
            stop  = (b > int'(high_model)) ? int'(high_model) : b;
            found = 1'b0;
            for (int i = a; i <= stop; i++) begin
              if (!found) begin
                if (bits_model[i]) begin
                  found       = 1'b1;
                  r.run_first = RUN_W'(i);
                  r.run_last  = RUN_W'(i);
                end
              end else begin
                if (!bits_model[i]) break;
                r.run_last = RUN_W'(i);
              end
            end
            r.result_flag = found;
          end
        end
        default: ;
      endcase
    end
    r.set_count    = pop_model;
    r.highest_seen = high_model;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    bits_model    = '0;
    pop_model     = '0;
    high_model    = '0;
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result transfer with no pending request");
          fail_count++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("result_flag", 32'(exp_r.result_flag),
                      32'(out_data.result_flag));
          check_field("run_first", 32'(exp_r.run_first), 32'(out_data.run_first));
          check_field("run_last", 32'(exp_r.run_last), 32'(out_data.run_last));
          check_field("set_count", 32'(exp_r.set_count), 32'(out_data.set_count));
          check_field("highest_seen", 32'(exp_r.highest_seen),
                      32'(out_data.highest_seen));
          check_field("out_of_range", 32'(exp_r.out_of_range),
                      32'(out_data.out_of_range));
        end
      end
      if (in_valid && in_ready) expected_rsp_q.push_back(apply_bitmap_op(in_data));
      pending_count = expected_rsp_q.size();
    end
  end
endmodule
`default_nettype wire

// ===== test/tb_bitmap_set_clear_range_scan.sv =====
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
`default_nettype none
module tb_bitmap_set_clear_range_scan;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1330;
  // longest quiet stretch: input idle gap + clear-all sweep + result stall, many times over
  localparam int IDLE_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  int   idle_cycles = 0;
  logic burst_mode = 1'b0;   // when set, neither side idles
  int   hot_base = 0;        // lower edge of the index window most items fall in

  bsc_if #(.T(req_t)) in_ch ();
  bsc_if #(.T(rsp_t)) out_ch ();

  always #4 clk = ~clk;

  bitmap_set_clear_range_scan i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bsc_scoreboard i_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, int a, int b);
    req_t r;
    r.operation = op;
    r.bit_index = IDX_W'(a);
    r.range_end = IDX_W'(b);
    return r;
  endfunction

  // one request transfer; valid stays high across back-to-back items
  task automatic send_req(req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // index mostly near a moving hot spot so bits collide and runs form
  function automatic int pick_index();
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 4095);
    v = hot_base + $urandom_range(0, 255);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic req_t random_req();
    int               w, a, b;
    logic [OP_W-1:0]  op;
    w = $urandom_range(0, 99);
    if      (w < 35) op = OP_SET;
    else if (w < 50) op = OP_TEST;
    else if (w < 65) op = OP_CLR;
    else if (w < 78) op = OP_CHECK;
    else if (w < 95) op = OP_FIND;
    else if (w < 97) op = OP_CLRA;
    else             op = OP_W'($urandom_range(6, 7));  // unused codes
    a = pick_index();
    w = $urandom_range(0, 9);
    if (w == 0)      b = $urandom_range(0, 4095);
    else if (w == 1) b = a - $urandom_range(1, 8);       // reversed range
    else             b = a + $urandom_range(0, 130);
    if (b < 0) b = 0;
    if (b > 4095) b = 4095;
    if ($urandom_range(0, 1)) return make_req(op, a, b);
    return make_req(op, a, $urandom_range(0, 4095) & (b | 12'hfff));
  endfunction

  // result side back-pressure, drawn per result
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: corner cases on an empty store first
    send_req(make_req(OP_CLRA, 0, 0));
    send_req(make_req(OP_CLR, 50, 0));          // clear above highest does nothing
    send_req(make_req(OP_TEST, 50, 0));         // test above highest reads 0
    send_req(make_req(OP_CHECK, 5, 3));         // empty range is all set
    send_req(make_req(OP_FIND, 7, 4095));       // start above highest, no run
    send_req(make_req(OP_SET, 0, 0));
    send_req(make_req(OP_SET, 1, 0));
    send_req(make_req(OP_SET, 2, 0));
    send_req(make_req(OP_SET, 3, 0));
    send_req(make_req(OP_SET, 3, 0));           // already set, count unchanged
    send_req(make_req(OP_CHECK, 0, 3));
    send_req(make_req(OP_CHECK, 0, 10));        // past highest reads as 0
    send_req(make_req(OP_FIND, 0, 4095));       // end clipped to highest
    send_req(make_req(OP_SET, 4095, 0));
    send_req(make_req(OP_TEST, 4095, 0));
    send_req(make_req(OP_TEST, 100, 0));
    send_req(make_req(OP_FIND, 5, 4095));
    send_req(make_req(OP_CHECK, 0, 4095));
    send_req(make_req(OP_CLR, 4095, 0));
    send_req(make_req(OP_CLR, 4095, 0));        // clear of a zero bit still succeeds
    send_req(make_req(3'd6, 4095, 4095));
    send_req(make_req(3'd7, 0, 0));
    send_req(make_req(OP_CLRA, 0, 0));          // highest kept, bits gone
    send_req(make_req(OP_TEST, 1, 0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        hot_base   = $urandom_range(0, 3840);
      end
      send_req(random_req());
    end
    in_ch.valid <= 1'b0;

    // drain, then let the last clear-all sweep finish
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
